// File: design/yuv2rgb_pkg.sv
// Shared item types, coefficients and clamp function of the YUV 4:2:0 to RGB converter.
package yuv2rgb_pkg;

    localparam int FW_W = 12;
    localparam logic [FW_W-1:0] FW_RESET = 12'd640;

    localparam int SUM_W = 28;

    localparam logic signed [18:0] COEF_Y  = 19'sd76310;
    localparam logic signed [18:0] COEF_RV = 19'sd104595;
    localparam logic signed [18:0] COEF_GU = 19'sd25677;
    localparam logic signed [18:0] COEF_GV = 19'sd53281;
    localparam logic signed [18:0] COEF_BU = 19'sd132199;

    localparam logic signed [8:0] LUMA_OFFSET   = 9'sd16;
    localparam logic signed [8:0] CHROMA_OFFSET = 9'sd128;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] luma_second;
        logic [7:0] chroma_u;
        logic [7:0] chroma_v;
        logic       frame_start;
    } in_item_t;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] luma_second;
        logic [7:0] chroma_u;
        logic [7:0] chroma_v;
        logic       row_end;
    } pair_t;

    typedef struct packed {
        logic [7:0] blue_first;
        logic [7:0] green_first;
        logic [7:0] red_first;
        logic [7:0] blue_second;
        logic [7:0] green_second;
        logic [7:0] red_second;
        logic       row_end;
    } out_item_t;

    function automatic logic [7:0] clamp_q16(input logic signed [SUM_W-1:0] sum);
        logic [7:0] res;
        if (sum[SUM_W-1]) begin
            res = 8'd0;
        end else if (sum[SUM_W-2:24] != '0) begin
            res = 8'd255;
        end else begin
            res = sum[23:16];
        end
        return res;
    endfunction

endpackage

// File: design/yuv2rgb_fifo.sv
// Small register-based first-in first-out queue with occupancy count.
module yuv2rgb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [WIDTH-1:0]             wdata,
    input  logic                         pop,
    output logic                         empty,
    output logic [WIDTH-1:0]             rdata,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = data_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: design/yuv2rgb_front.sv
// Front part: width register, row and column tracking, and the chroma line buffer.
module yuv2rgb_front
    import yuv2rgb_pkg::*;
#(
    parameter int LINE_PAIRS = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    input  logic [FW_W-1:0] cfg_data,
    input  logic            push,
    output logic            full,
    input  in_item_t        pair,
    output logic            mid_push,
    input  logic            mid_full,
    output pair_t           mid_item
);

    localparam int COL_W = (LINE_PAIRS > 1) ? $clog2(LINE_PAIRS) : 1;
    localparam int PW = (COL_W + 1 > FW_W - 1) ? COL_W + 1 : FW_W - 1;

    logic [FW_W-1:0]  frame_width_reg;
    logic [PW-1:0]    half;
    logic [COL_W-1:0] last_col;
    logic [COL_W-1:0] col_reg, col_next;
    logic             odd_reg, odd_next;
    logic [COL_W-1:0] col_base;
    logic [COL_W-1:0] col;
    logic             odd_now;
    logic             last;
    logic             accept;
    logic             s1_valid_reg, s1_valid_next;
    pair_t            s1_reg;
    logic             s1_odd_reg;
    logic [15:0]      chroma_mem [LINE_PAIRS];
    logic [15:0]      mem_q_reg;

    assign half = PW'(frame_width_reg[FW_W-1:1]);

    always_comb
    begin
        if (half == '0)
        begin
            last_col = '0;
        end
        else if (half > PW'(LINE_PAIRS))
        begin
            last_col = COL_W'(LINE_PAIRS - 1);
        end
        else
        begin
            last_col = COL_W'(half - PW'(1));
        end
    end

    assign full     = s1_valid_reg && mid_full;
    assign accept   = push && !full;
    assign col_base = pair.frame_start ? '0 : col_reg;
    assign odd_now  = pair.frame_start ? 1'b0 : odd_reg;
    assign col      = (col_base > last_col) ? last_col : col_base;
    assign last     = (col_base >= last_col);

    always_comb
    begin
        col_next      = col_reg;
        odd_next      = odd_reg;
        s1_valid_next = accept || (s1_valid_reg && mid_full);
        if (accept)
        begin
            col_next = last ? '0 : col_base + COL_W'(1);
            odd_next = last ? !odd_now : odd_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= FW_RESET;
            col_reg         <= '0;
            odd_reg         <= 1'b0;
            s1_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                frame_width_reg <= cfg_data;
            end
            col_reg      <= col_next;
            odd_reg      <= odd_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg.luma_first  <= pair.luma_first;
            s1_reg.luma_second <= pair.luma_second;
            s1_reg.chroma_u    <= pair.chroma_u;
            s1_reg.chroma_v    <= pair.chroma_v;
            s1_reg.row_end     <= last;
            s1_odd_reg         <= odd_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !odd_now)
        begin
            chroma_mem[col] <= {pair.chroma_v, pair.chroma_u};
        end
        if (accept && odd_now)
        begin
            mem_q_reg <= chroma_mem[col];
        end
    end

    assign mid_push = s1_valid_reg;

    always_comb
    begin
        mid_item = s1_reg;
        if (s1_odd_reg)
        begin
            mid_item.chroma_u = mem_q_reg[7:0];
            mid_item.chroma_v = mem_q_reg[15:8];
        end
    end

endmodule

// File: design/yuv2rgb_back.sv
// Back part: BT.601 conversion pipeline feeding the result queue.
module yuv2rgb_back
    import yuv2rgb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      mid_empty,
    input  pair_t     mid_item,
    output logic      mid_pop,
    input  logic      pop,
    output logic      empty,
    output out_item_t result
);

    localparam int OUT_DEPTH = 4;
    localparam int OCW = $clog2(OUT_DEPTH + 1);

    logic signed [8:0]       yd1, yd2, ud, vd;
    logic signed [SUM_W-1:0] yt1_reg, yt2_reg, bu_reg, gu_reg, gv_reg, rv_reg;
    logic                    row_end_reg;
    logic                    p_valid_reg;
    logic signed [SUM_W-1:0] b1, g1, r1, b2, g2, r2;
    out_item_t               conv;
    logic [OCW-1:0]          out_count;
    logic [OCW:0]            occupancy;
    logic                    out_full;

    assign yd1 = $signed({1'b0, mid_item.luma_first}) - LUMA_OFFSET;
    assign yd2 = $signed({1'b0, mid_item.luma_second}) - LUMA_OFFSET;
    assign ud  = $signed({1'b0, mid_item.chroma_u}) - CHROMA_OFFSET;
    assign vd  = $signed({1'b0, mid_item.chroma_v}) - CHROMA_OFFSET;

    assign occupancy = {1'b0, out_count} + (OCW + 1)'(p_valid_reg);
    assign mid_pop   = !mid_empty && (occupancy < (OCW + 1)'(OUT_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= mid_pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_pop)
        begin
            yt1_reg     <= SUM_W'(yd1) * SUM_W'(COEF_Y);
            yt2_reg     <= SUM_W'(yd2) * SUM_W'(COEF_Y);
            bu_reg      <= SUM_W'(ud) * SUM_W'(COEF_BU);
            gu_reg      <= SUM_W'(ud) * SUM_W'(COEF_GU);
            gv_reg      <= SUM_W'(vd) * SUM_W'(COEF_GV);
            rv_reg      <= SUM_W'(vd) * SUM_W'(COEF_RV);
            row_end_reg <= mid_item.row_end;
        end
    end

    assign b1 = yt1_reg + bu_reg;
    assign g1 = yt1_reg - gu_reg - gv_reg;
    assign r1 = yt1_reg + rv_reg;
    assign b2 = yt2_reg + bu_reg;
    assign g2 = yt2_reg - gu_reg - gv_reg;
    assign r2 = yt2_reg + rv_reg;

    always_comb
    begin
        conv.blue_first   = clamp_q16(b1);
        conv.green_first  = clamp_q16(g1);
        conv.red_first    = clamp_q16(r1);
        conv.blue_second  = clamp_q16(b2);
        conv.green_second = clamp_q16(g2);
        conv.red_second   = clamp_q16(r2);
        conv.row_end      = row_end_reg;
    end

    yuv2rgb_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (p_valid_reg),
        .full  (out_full),
        .wdata (conv),
        .pop   (pop),
        .empty (empty),
        .rdata (result),
        .count (out_count)
    );

endmodule

// File: design/yuv420_to_rgb32_converter.sv
// A pair passes the front register, middle queue, product registers and output queue.
// Throughput: one pixel pair per cycle, sustained while results are popped.
// The rate is set by the single-port chroma line buffer, one access per pair.
// Reset clears the row and column position, the queues and the pipeline valid flags,
// and sets the width register to 640; the chroma line buffer is not cleared.
module yuv420_to_rgb32_converter
    import yuv2rgb_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [FW_W-1:0] cfg_data,
    input  logic            push,
    output logic            full,
    input  in_item_t        pair,
    output logic            empty,
    input  logic            pop,
    output out_item_t       result
);

    localparam int LINE_PAIRS = MAX_WIDTH / 2;
    localparam int MID_DEPTH = 4;

    logic                           mid_push;
    logic                           mid_full;
    logic                           mid_pop;
    logic                           mid_empty;
    pair_t                          mid_wdata;
    pair_t                          mid_rdata;
    logic [$clog2(MID_DEPTH+1)-1:0] mid_count;

    assign cfg_ready = 1'b1;

    yuv2rgb_front #(
        .LINE_PAIRS (LINE_PAIRS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .pair      (pair),
        .mid_push  (mid_push),
        .mid_full  (mid_full),
        .mid_item  (mid_wdata)
    );

    yuv2rgb_fifo #(
        .WIDTH ($bits(pair_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .full  (mid_full),
        .wdata (mid_wdata),
        .pop   (mid_pop),
        .empty (mid_empty),
        .rdata (mid_rdata),
        .count (mid_count)
    );

    yuv2rgb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty || (mid_count == '0)),
        .mid_item  (mid_rdata),
        .mid_pop   (mid_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

// File: verif/yuv420_to_rgb32_checker.sv
// Checker that predicts and compares the converted pixel pairs of the YUV 4:2:0 to RGB converter.
module yuv420_to_rgb32_checker
    import yuv2rgb_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    input  logic            cfg_ready,
    input  logic [FW_W-1:0] cfg_data,
    input  logic            push,
    input  logic            full,
    input  in_item_t        pair,
    input  logic            empty,
    input  logic            pop,
    input  out_item_t       result,
    input  logic            drain_check,
    output int              errors,
    output int              pending
);

    localparam int LINE_PAIRS = 1024;
    localparam int Y_GAIN     = 76310;
    localparam int RV_GAIN    = 104595;
    localparam int GU_GAIN    = 25677;
    localparam int GV_GAIN    = 53281;
    localparam int BU_GAIN    = 132199;

    logic [FW_W-1:0] width_reg;
    logic [15:0]     line_chroma [LINE_PAIRS];
    int              col_pos;
    logic            on_odd_row;
    logic            drain_seen;
    out_item_t       expected_pixels [$];

    initial begin
        errors  = 0;
        pending = 0;
    end

    function automatic logic [7:0] clamp_byte(input int sum);
        int q;
        q = sum >>> 16;
        if (sum < 0) begin
            return 8'd0;
        end
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function automatic logic [23:0] pixel_bgr(input logic [7:0] luma, input logic [7:0] cb,
                                              input logic [7:0] cr);
        int yt;
        int ud;
        int vd;
        yt = Y_GAIN * (int'(luma) - 16);
        ud = int'(cb) - 128;
        vd = int'(cr) - 128;
        return {clamp_byte(yt + BU_GAIN * ud),
                clamp_byte(yt - GU_GAIN * ud - GV_GAIN * vd),
                clamp_byte(yt + RV_GAIN * vd)};
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : predict_and_check
        int        pairs;
        int        col;
        logic [7:0] cb;
        logic [7:0] cr;
        logic      last;
        out_item_t want;
        if (!rst_n) begin
            width_reg  = FW_RESET;
            col_pos    = 0;
            on_odd_row = 1'b0;
            drain_seen = 1'b0;
            expected_pixels.delete();
            pending    = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                width_reg = cfg_data;
            end
            if (pop && !empty) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: result item with no expectation, actual %h", $time, result);
                    errors++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("blue_first", want.blue_first, result.blue_first);
                    check_field("green_first", want.green_first, result.green_first);
                    check_field("red_first", want.red_first, result.red_first);
                    check_field("blue_second", want.blue_second, result.blue_second);
                    check_field("green_second", want.green_second, result.green_second);
                    check_field("red_second", want.red_second, result.red_second);
                    check_field("row_end", 8'(want.row_end), 8'(result.row_end));
                end
            end
            if (push && !full) begin
                pairs = int'(width_reg) >> 1;
                if (pairs < 1) begin
                    pairs = 1;
                end
                if (pairs > LINE_PAIRS) begin
                    pairs = LINE_PAIRS;
                end
                if (pair.frame_start) begin
                    col_pos    = 0;
                    on_odd_row = 1'b0;
                end
                col = (col_pos >= pairs) ? pairs - 1 : col_pos;
                if (!on_odd_row) begin
                    cb = pair.chroma_u;
                    cr = pair.chroma_v;
                    line_chroma[col] = {cr, cb};
                end else begin
                    {cr, cb} = line_chroma[col];
                end
                {want.blue_first, want.green_first, want.red_first} =
                    pixel_bgr(pair.luma_first, cb, cr);
                {want.blue_second, want.green_second, want.red_second} =
                    pixel_bgr(pair.luma_second, cb, cr);
                last = (col_pos >= pairs - 1);
                want.row_end = last;
                expected_pixels.push_back(want);
                if (last) begin
                    col_pos    = 0;
                    on_odd_row = !on_odd_row;
                end else begin
                    col_pos = col_pos + 1;
                end
            end
            if (drain_check && !drain_seen) begin
                drain_seen = 1'b1;
                foreach (expected_pixels[i]) begin
                    $display("%0t: expected item never arrived, expected %h, actual none",
                             $time, expected_pixels[i]);
                    errors++;
                end
            end
            pending = expected_pixels.size();
        end
    end

endmodule

// File: verif/tb_yuv420_to_rgb32_converter.sv
// Top of the converter testbench: clock, reset, stimulus, watchdog and verdict.
module tb_yuv420_to_rgb32_converter;
    import yuv2rgb_pkg::*;

    localparam int RANDOM_ITEMS = 1850;
    localparam int STALL_LIMIT  = 1000;

    logic            clk;
    logic            rst_n;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [FW_W-1:0] cfg_data;
    logic            push;
    logic            full;
    in_item_t        pair;
    logic            empty;
    logic            pop;
    out_item_t       result;
    logic            drain_check;
    int              errors;
    int              pending;
    int              idle_pct = 38;
    int              stall_cycles;

    yuv420_to_rgb32_converter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .pair      (pair),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    yuv420_to_rgb32_checker pixel_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .pair        (pair),
        .empty       (empty),
        .pop         (pop),
        .result      (result),
        .drain_check (drain_check),
        .errors      (errors),
        .pending     (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        pop = 1'b0;
        forever begin
            @(negedge clk);
            pop = ($urandom_range(99) >= idle_pct);
        end
    end

    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [7:0] pick_sample();
        case ($urandom_range(9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_pair(input logic [7:0] y0, input logic [7:0] y1, input logic [7:0] cb,
                             input logic [7:0] cr, input logic fs);
        while ($urandom_range(99) < idle_pct) begin
            push = 1'b0;
            @(negedge clk);
        end
        push              = 1'b1;
        pair.luma_first   = y0;
        pair.luma_second  = y1;
        pair.chroma_u     = cb;
        pair.chroma_v     = cr;
        pair.frame_start  = fs;
        @(posedge clk);
        while (full) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic wait_drained();
        push = 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
    endtask

    task automatic write_width(input logic [FW_W-1:0] w);
        wait_drained();
        repeat (8) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = w;
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_phase(input int count, input logic stress);
        for (int k = 0; k < count; k++) begin
            idle_pct = (stress && k < 400) ? 0 : 38;
            if (stress && k == 700) begin
                wait_drained();
            end
            send_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                      (k == 0) || ($urandom_range(99) < 3));
        end
        idle_pct = 38;
    endtask

    initial begin : stimulus
        logic [FW_W-1:0] w;
        int              n;
        int              sent;
        int              phase;
        rst_n       = 1'b0;
        push        = 1'b0;
        pair        = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        drain_check = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_width(12'd4);
        send_pair(8'd0, 8'd255, 8'd0, 8'd255, 1'b1);
        send_pair(8'd255, 8'd0, 8'd255, 8'd0, 1'b0);
        send_pair(8'd16, 8'd235, pick_sample(), pick_sample(), 1'b0);
        send_pair(8'd128, 8'd128, pick_sample(), pick_sample(), 1'b0);
        send_pair(8'd235, 8'd16, 8'd128, 8'd128, 1'b0);
        send_pair(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        send_pair(8'd0, 8'd0, pick_sample(), pick_sample(), 1'b0);
        send_pair(8'd255, 8'd255, pick_sample(), pick_sample(), 1'b0);
        send_pair(8'd100, 8'd200, 8'd90, 8'd240, 1'b0);
        send_pair(8'd50, 8'd60, 8'd200, 8'd30, 1'b1);
        send_pair(8'd70, 8'd80, 8'd10, 8'd250, 1'b0);

        // The row is left mid-way, then the width shrinks below the current column.
        write_width(12'd12);
        for (int k = 0; k < 4; k++) begin
            send_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample(), k == 0);
        end
        write_width(12'd5);
        for (int k = 0; k < 3; k++) begin
            send_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample(), 1'b0);
        end

        write_width(12'd0);
        for (int k = 0; k < 3; k++) begin
            send_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample(), k == 0);
        end
        write_width(12'd1);
        for (int k = 0; k < 2; k++) begin
            send_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample(), k == 0);
        end

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            case (phase)
                0: begin
                    w = 12'd4095;
                    n = 1030;
                end
                1: begin
                    w = 12'd2048;
                    n = 60;
                end
                2: begin
                    w = 12'd2;
                    n = 40;
                end
                default: begin
                    w = ($urandom_range(5) == 0) ? FW_W'($urandom_range(41, 300))
                                                 : FW_W'($urandom_range(0, 40));
                    n = $urandom_range(20, 120);
                end
            endcase
            write_width(w);
            random_phase(n, phase == 0);
            sent += n;
            phase++;
        end

        wait_drained();
        repeat (10) @(negedge clk);
        drain_check = 1'b1;
        @(negedge clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
